FILE: design/alpw_pkg.sv
// Shared types and codes for the antialiased line pixel walker.
package alpw_pkg;

   // Request selector carried in req_tuser
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_FETCH = 1'b1;

   // Line modes
   localparam logic [1:0] MODE_IDLE     = 2'd0;
   localparam logic [1:0] MODE_SPAN     = 2'd1;
   localparam logic [1:0] MODE_DIAG     = 2'd2;
   localparam logic [1:0] MODE_WEIGHTED = 2'd3;

   // Emit phases; the span walk reuses PH_FAR_PRIME as its "keep stepping" phase
   localparam logic [2:0] PH_NEAR_END  = 3'd0;
   localparam logic [2:0] PH_FAR_END   = 3'd1;
   localparam logic [2:0] PH_STEP      = 3'd2;
   localparam logic [2:0] PH_FAR_PRIME = 3'd3;
   localparam logic [2:0] PH_NEAR_PAIR = 3'd4;
   localparam logic [2:0] PH_FAR_PAIR  = 3'd5;

   // Pixel kinds
   localparam logic [1:0] KIND_SOLID   = 2'd0;
   localparam logic [1:0] KIND_PRIMARY = 2'd1;
   localparam logic [1:0] KIND_PAIRED  = 2'd2;

   localparam int WEIGHT_BITS = 8;
   localparam int COLOR_BITS  = 8;

   typedef struct packed {
      logic load;      // start word accepted
      logic fetch;     // fetch word accepted
      logic div_step;  // advance the divider one quotient bit
   } alpw_cmd_type;

   typedef struct packed {
      logic start_weighted;  // start word on the input describes a weighted line
      logic line_active;     // a line is in progress
   } alpw_sts_type;

endpackage

FILE: design/alpw_ctrl.sv
// Controller: handshake, divider sequencing and result valid.
module alpw_ctrl #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tuser,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  alpw_pkg::alpw_sts_type sts,
   output alpw_pkg::alpw_cmd_type cmd
);
   import alpw_pkg::*;

   localparam int CNT_BITS = $clog2(FRACTION_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(FRACTION_BITS - 1);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_DIVIDE = 1'b1;

   logic                state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                valid_ff, valid_in;
   logic                accept;

   assign req_tready = (state_ff == ST_IDLE) && (!valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = valid_ff;

   always_comb begin
      cmd.load     = accept && (req_tuser == REQ_START);
      cmd.fetch    = accept && (req_tuser == REQ_FETCH);
      cmd.div_step = (state_ff == ST_DIVIDE);
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (cmd.load && sts.start_weighted) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.fetch && sts.line_active) valid_in = 1'b1;
      else if (rsp_tready)              valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

endmodule

FILE: design/alpw_datapath.sv
// Datapath: line setup, bit-serial error step divider and pixel walker.
module alpw_datapath #(
   parameter int COORD_BITS    = 8,
   parameter int FRACTION_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  alpw_pkg::alpw_cmd_type          cmd,
   output alpw_pkg::alpw_sts_type          sts,
   input  logic [COORD_BITS-1:0]           x_start,
   input  logic [COORD_BITS-1:0]           y_start,
   input  logic [COORD_BITS-1:0]           x_end,
   input  logic [COORD_BITS-1:0]           y_end,
   input  logic [alpw_pkg::COLOR_BITS-1:0] line_color,
   output logic [COORD_BITS-1:0]           pixel_x,
   output logic [COORD_BITS-1:0]           pixel_y,
   output logic [alpw_pkg::WEIGHT_BITS-1:0] weight,
   output logic [1:0]                      pixel_kind,
   output logic [alpw_pkg::COLOR_BITS-1:0] color_out,
   output logic                            last
);
   import alpw_pkg::*;

   localparam int C = COORD_BITS;
   localparam int F = FRACTION_BITS;

   // Walker state
   logic [C-1:0] near_x_ff, near_x_in, near_y_ff, near_y_in;
   logic [C-1:0] far_x_ff, far_x_in, far_y_ff, far_y_in;
   logic [F-1:0] acc_ff, acc_in;
   logic [F-1:0] quot_ff, quot_in;
   logic [C:0]   rem_ff, rem_in;
   logic [C-1:0] div_ff, div_in;
   logic         swapped_ff, swapped_in;
   logic         left_ff, left_in;
   logic [C-1:0] steps_ff, steps_in;
   logic [1:0]   mode_ff, mode_in;
   logic [2:0]   phase_ff, phase_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;

   // Result register
   logic [C-1:0]           px_ff, px_in, py_ff, py_in;
   logic [WEIGHT_BITS-1:0] w_ff, w_in;
   logic [1:0]             kind_ff, kind_in;
   logic                   last_ff, last_in;

   // Setup
   logic [C-1:0] dx, dy, mi1, ma1, mi2, ma2, dmin, dmaj;
   logic [C-1:0] n_mi, n_ma, f_mi, f_ma;
   logic         do_swap;
   logic [1:0]   start_mode;

   // Divider
   logic [C:0] rem_shift;
   logic       rem_ge;

   // Pixel selection
   logic [C-1:0] o_minor, o_major;
   logic [1:0]   o_kind;
   logic         o_last;
   logic [F-1:0] acc_sum, w_src;
   logic         acc_wrap;

   function automatic logic [COORD_BITS-1:0] minor_fwd(input logic [COORD_BITS-1:0] v,
                                                      input logic lft);
      return lft ? v - 1'b1 : v + 1'b1;
   endfunction

   function automatic logic [COORD_BITS-1:0] minor_back(input logic [COORD_BITS-1:0] v,
                                                       input logic lft);
      return lft ? v + 1'b1 : v - 1'b1;
   endfunction

   // Line setup from the start word: make y the major axis, order top to bottom
   always_comb begin
      dx      = (x_start > x_end) ? x_start - x_end : x_end - x_start;
      dy      = (y_start > y_end) ? y_start - y_end : y_end - y_start;
      do_swap = dx > dy;
      dmin    = do_swap ? dy : dx;
      dmaj    = do_swap ? dx : dy;
      mi1     = do_swap ? y_start : x_start;
      ma1     = do_swap ? x_start : y_start;
      mi2     = do_swap ? y_end : x_end;
      ma2     = do_swap ? x_end : y_end;
      if (ma1 > ma2) begin
         n_mi = mi2; n_ma = ma2; f_mi = mi1; f_ma = ma1;
      end else begin
         n_mi = mi1; n_ma = ma1; f_mi = mi2; f_ma = ma2;
      end
      if (dmaj == '0 || dmin == '0) start_mode = MODE_SPAN;
      else if (dmin == dmaj)        start_mode = MODE_DIAG;
      else                          start_mode = MODE_WEIGHTED;
   end

   assign sts.start_weighted = (start_mode == MODE_WEIGHTED);
   assign sts.line_active    = (mode_ff != MODE_IDLE);

   // Restoring division, one quotient bit per step
   assign rem_shift = {rem_ff[C-1:0], 1'b0};
   assign rem_ge    = rem_shift >= {1'b0, div_ff};

   // Pixel walker
   always_comb begin
      near_x_in = near_x_ff;
      near_y_in = near_y_ff;
      far_x_in  = far_x_ff;
      far_y_in  = far_y_ff;
      acc_in    = acc_ff;
      steps_in  = steps_ff;
      mode_in   = mode_ff;
      phase_in  = phase_ff;
      o_minor   = near_x_ff;
      o_major   = near_y_ff;
      o_kind    = KIND_SOLID;
      o_last    = 1'b0;
      w_src     = acc_ff;
      acc_sum   = acc_ff + quot_ff;
      acc_wrap  = acc_sum <= acc_ff;

      if (phase_ff == PH_NEAR_END) begin
         phase_in = PH_FAR_END;
      end else if (phase_ff == PH_FAR_END) begin
         o_minor  = far_x_ff;
         o_major  = far_y_ff;
         phase_in = PH_STEP;
      end else begin
         case (mode_ff)
            MODE_SPAN: begin
               // first span pixel repeats the near end
               if (phase_ff != PH_STEP) near_y_in = near_y_ff + 1'b1;
               o_major = near_y_in;
               o_last  = (near_y_in == far_y_ff);
               if (o_last) mode_in = MODE_IDLE;
               else        phase_in = PH_FAR_PRIME;
            end
            MODE_DIAG: begin
               near_x_in = minor_fwd(near_x_ff, left_ff);
               near_y_in = near_y_ff + 1'b1;
               o_minor   = near_x_in;
               o_major   = near_y_in;
               o_last    = (near_y_in == far_y_ff);
               if (o_last) mode_in = MODE_IDLE;
            end
            default: begin
               case (phase_ff)
                  PH_STEP: begin
                     acc_in = acc_sum;
                     w_src  = acc_sum;
                     if (acc_wrap) begin
                        near_x_in = minor_fwd(near_x_ff, left_ff);
                        far_x_in  = minor_back(far_x_ff, left_ff);
                     end
                     near_y_in = near_y_ff + 1'b1;
                     far_y_in  = far_y_ff - 1'b1;
                     o_minor   = near_x_in;
                     o_major   = near_y_in;
                     o_kind    = KIND_PRIMARY;
                     phase_in  = PH_FAR_PRIME;
                  end
                  PH_FAR_PRIME: begin
                     o_minor  = far_x_ff;
                     o_major  = far_y_ff;
                     o_kind   = KIND_PRIMARY;
                     phase_in = PH_NEAR_PAIR;
                  end
                  PH_NEAR_PAIR: begin
                     o_minor  = minor_fwd(near_x_ff, left_ff);
                     o_kind   = KIND_PAIRED;
                     phase_in = PH_FAR_PAIR;
                  end
                  default: begin
                     o_minor = minor_back(far_x_ff, left_ff);
                     o_major = far_y_ff;
                     o_kind  = KIND_PAIRED;
                     o_last  = (steps_ff <= C'(1));
                     if (o_last) begin
                        steps_in = '0;
                        mode_in  = MODE_IDLE;
                     end else begin
                        steps_in = steps_ff - 1'b1;
                        phase_in = PH_STEP;
                     end
                  end
               endcase
            end
         endcase
      end

      px_in   = swapped_ff ? o_major : o_minor;
      py_in   = swapped_ff ? o_minor : o_major;
      w_in    = (o_kind == KIND_SOLID) ? '0 : w_src[F-1 -: WEIGHT_BITS];
      kind_in = o_kind;
      last_in = o_last;
   end

   // Register update selection
   logic [C-1:0] nx_next, ny_next, fx_next, fy_next, steps_next;
   logic [F-1:0] acc_next, quot_next;
   logic [1:0]   mode_next;
   logic [2:0]   phase_next;

   always_comb begin
      nx_next    = near_x_ff;
      ny_next    = near_y_ff;
      fx_next    = far_x_ff;
      fy_next    = far_y_ff;
      acc_next   = acc_ff;
      steps_next = steps_ff;
      mode_next  = mode_ff;
      phase_next = phase_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      div_in     = div_ff;
      swapped_in = swapped_ff;
      left_in    = left_ff;
      color_in   = color_ff;
      if (cmd.load) begin
         nx_next    = n_mi;
         ny_next    = n_ma;
         fx_next    = f_mi;
         fy_next    = f_ma;
         acc_next   = '0;
         steps_next = sts.start_weighted ? (dmaj >> 1) : '0;
         mode_next  = start_mode;
         phase_next = PH_NEAR_END;
         quot_in    = '0;
         rem_in     = {1'b0, dmin};
         div_in     = dmaj;
         swapped_in = do_swap;
         left_in    = n_mi > f_mi;
         color_in   = line_color;
      end else if (cmd.div_step) begin
         quot_in = {quot_ff[F-2:0], rem_ge};
         rem_in  = rem_ge ? rem_shift - {1'b0, div_ff} : rem_shift;
      end else if (cmd.fetch && sts.line_active) begin
         nx_next    = near_x_in;
         ny_next    = near_y_in;
         fx_next    = far_x_in;
         fy_next    = far_y_in;
         acc_next   = acc_in;
         steps_next = steps_in;
         mode_next  = mode_in;
         phase_next = phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         phase_ff <= PH_NEAR_END;
      end else begin
         mode_ff  <= mode_next;
         phase_ff <= phase_next;
      end
   end

   always_ff @(posedge clock) begin
      near_x_ff  <= nx_next;
      near_y_ff  <= ny_next;
      far_x_ff   <= fx_next;
      far_y_ff   <= fy_next;
      acc_ff     <= acc_next;
      steps_ff   <= steps_next;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      div_ff     <= div_in;
      swapped_ff <= swapped_in;
      left_ff    <= left_in;
      color_ff   <= color_in;
   end

   // Hold the result word until the next fetch that produces a pixel
   always_ff @(posedge clock) begin
      if (cmd.fetch && sts.line_active) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         w_ff    <= w_in;
         kind_ff <= kind_in;
         last_ff <= last_in;
      end
   end

   assign pixel_x    = px_ff;
   assign pixel_y    = py_ff;
   assign weight     = w_ff;
   assign pixel_kind = kind_ff;
   assign color_out  = color_ff;
   assign last       = last_ff;

endmodule

FILE: design/antialiased_line_pixel_walker_core.sv
// Antialiased line pixel walker: top level joining controller and datapath.
// Fetch word: pixel is registered and shown in the cycle after acceptance; one fetch per cycle
//   is taken while the result side keeps up.
// Start word: span and diagonal lines are loaded on acceptance; a weighted line then runs
//   the bit-serial divider (one quotient bit per cycle), ready low meanwhile.
// Reset (synchronous, active high) drops any line in progress and clears result valid.
module antialiased_line_pixel_walker_core #(
   parameter int COORD_BITS    = 8,
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // x_start, y_start, x_end, y_end, line_color
   input  logic [((4*COORD_BITS+8+7)/8)*8-1:0] req_tdata,
   // req_type
   input  logic [0:0]               req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // pixel_x, pixel_y, weight, color_out
   output logic [((2*COORD_BITS+16+7)/8)*8-1:0] rsp_tdata,
   // pixel_kind
   output logic [1:0]               rsp_tuser,
   output logic                     rsp_tlast
);
   import alpw_pkg::*;

   localparam int C             = COORD_BITS;
   localparam int RSP_DATA_BITS = ((2*COORD_BITS+16+7)/8)*8;

   alpw_cmd_type cmd;
   alpw_sts_type sts;

   logic [C-1:0]           pixel_x, pixel_y;
   logic [WEIGHT_BITS-1:0] weight;
   logic [COLOR_BITS-1:0]  color_out;

   alpw_ctrl #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser[0]),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   alpw_datapath #(
      .COORD_BITS    (COORD_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .x_start    (req_tdata[C-1:0]),
      .y_start    (req_tdata[2*C-1 -: C]),
      .x_end      (req_tdata[3*C-1 -: C]),
      .y_end      (req_tdata[4*C-1 -: C]),
      .line_color (req_tdata[4*C+COLOR_BITS-1 -: COLOR_BITS]),
      .pixel_x    (pixel_x),
      .pixel_y    (pixel_y),
      .weight     (weight),
      .pixel_kind (rsp_tuser),
      .color_out  (color_out),
      .last       (rsp_tlast)
   );

   assign rsp_tdata = RSP_DATA_BITS'({color_out, weight, pixel_y, pixel_x});

   // No new word while a result is stuck at the output
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while result stalled");

   // A weighted start blocks input while the divider runs
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[0] == REQ_START && sts.start_weighted)
      |=> !req_tready)
      else $error("input taken during divide");

   // Solid pixels carry no weight
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_SOLID) |-> (weight == '0))
      else $error("solid pixel with nonzero weight");

   // A fetch on an idle line produces no result
   assert property (@(posedge clock) disable iff (reset)
      (cmd.fetch && !sts.line_active && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("result from idle line");

endmodule

FILE: tb/alpw_pixel_checker.sv
// Pixel word checker for the line walker core: tracks each line walk and compares results.
module alpw_pixel_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // x_start, y_start, x_end, y_end, line_color
   input  logic [39:0] req_tdata,
   // req_type
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pixel_x, pixel_y, weight, color_out
   input  logic [31:0] rsp_tdata,
   // pixel_kind
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        run_over,
   output int          failures,
   output int          pending
);
   import alpw_pkg::*;

   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] weight;
      logic [1:0] kind;
      logic [7:0] color;
      logic       last;
   } pixel_type;

   pixel_type   pending_pixels[$];
   pixel_type   want;
   logic [7:0]  near_x, near_y, far_x, far_y;
   logic [15:0] err_acc, err_step;
   logic        swapped, step_left, swept;
   logic [7:0]  steps_left;
   logic [1:0]  mode;
   logic [2:0]  phase;
   logic [7:0]  color;

   function automatic logic [7:0] minor_fwd(input logic [7:0] v);
      return step_left ? v - 8'd1 : v + 8'd1;
   endfunction

   function automatic logic [7:0] minor_back(input logic [7:0] v);
      return step_left ? v + 8'd1 : v - 8'd1;
   endfunction

   // Map minor/major back to screen axes; solid pixels carry no weight
   function automatic pixel_type make_pixel(input logic [7:0] minor, input logic [7:0] major,
                                            input logic [1:0] kind, input logic is_last);
      pixel_type p;
      p.x      = swapped ? major : minor;
      p.y      = swapped ? minor : major;
      p.weight = (kind != KIND_SOLID) ? err_acc[15:8] : 8'd0;
      p.kind   = kind;
      p.color  = color;
      p.last   = is_last;
      return p;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int expected);
      if (failures < PRINT_LIMIT)
         $display("pixel error at cycle time %0t: %s got %0d, expected %0d",
                  $realtime, what, got, expected);
      failures++;
   endtask

   task automatic load_line(input logic [39:0] d);
      logic [7:0]  x1, y1, x2, y2, t, dx, dy;
      logic [31:0] quotient;
      x1 = d[7:0];
      y1 = d[15:8];
      x2 = d[23:16];
      y2 = d[31:24];
      color = d[39:32];
      dy = (y1 > y2) ? y1 - y2 : y2 - y1;
      dx = (x1 > x2) ? x1 - x2 : x2 - x1;
      swapped = 1'b0;
      // make the longer axis the major one
      if (dx > dy) begin
         t = dx; dx = dy; dy = t;
         t = x1; x1 = y1; y1 = t;
         t = x2; x2 = y2; y2 = t;
         swapped = 1'b1;
      end
      if (y1 > y2) begin
         t = y1; y1 = y2; y2 = t;
         t = x1; x1 = x2; x2 = t;
      end
      step_left = (x1 > x2);
      near_x = x1;
      near_y = y1;
      far_x = x2;
      far_y = y2;
      err_acc = 16'd0;
      err_step = 16'd0;
      steps_left = 8'd0;
      phase = PH_NEAR_END;
      if (dy == 8'd0 || dx == 8'd0) begin
         mode = MODE_SPAN;
      end else if (dx == dy) begin
         mode = MODE_DIAG;
      end else begin
         mode = MODE_WEIGHTED;
         quotient = (32'(dx) << 16) / 32'(dy);
         err_step = quotient[15:0];
         steps_left = dy >> 1;
      end
   endtask

   task automatic next_pixel();
      logic [15:0] prev;
      logic        is_last;
      pixel_type   p;
      if (mode != MODE_IDLE) begin
         if (phase == PH_NEAR_END) begin
            p = make_pixel(near_x, near_y, KIND_SOLID, 1'b0);
            phase = PH_FAR_END;
         end else if (phase == PH_FAR_END) begin
            p = make_pixel(far_x, far_y, KIND_SOLID, 1'b0);
            phase = PH_STEP;
         end else if (mode == MODE_SPAN) begin
            // first span pixel repeats the near end, then advance
            if (phase != PH_STEP)
               near_y = near_y + 8'd1;
            is_last = (near_y == far_y);
            p = make_pixel(near_x, near_y, KIND_SOLID, is_last);
            if (is_last)
               mode = MODE_IDLE;
            else
               phase = PH_FAR_PRIME;
         end else if (mode == MODE_DIAG) begin
            near_x = minor_fwd(near_x);
            near_y = near_y + 8'd1;
            is_last = (near_y == far_y);
            p = make_pixel(near_x, near_y, KIND_SOLID, is_last);
            if (is_last)
               mode = MODE_IDLE;
         end else begin
            case (phase)
               PH_STEP: begin
                  prev = err_acc;
                  err_acc = err_acc + err_step;
                  // accumulator wrap means a minor step on both ends
                  if (err_acc <= prev) begin
                     near_x = minor_fwd(near_x);
                     far_x = minor_back(far_x);
                  end
                  near_y = near_y + 8'd1;
                  far_y = far_y - 8'd1;
                  p = make_pixel(near_x, near_y, KIND_PRIMARY, 1'b0);
                  phase = PH_FAR_PRIME;
               end
               PH_FAR_PRIME: begin
                  p = make_pixel(far_x, far_y, KIND_PRIMARY, 1'b0);
                  phase = PH_NEAR_PAIR;
               end
               PH_NEAR_PAIR: begin
                  p = make_pixel(minor_fwd(near_x), near_y, KIND_PAIRED, 1'b0);
                  phase = PH_FAR_PAIR;
               end
               default: begin
                  is_last = (steps_left <= 8'd1);
                  p = make_pixel(minor_back(far_x), far_y, KIND_PAIRED, is_last);
                  if (is_last) begin
                     steps_left = 8'd0;
                     mode = MODE_IDLE;
                  end else begin
                     steps_left = steps_left - 8'd1;
                     phase = PH_STEP;
                  end
               end
            endcase
         end
         pending_pixels.push_back(p);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         near_x = 8'd0;
         near_y = 8'd0;
         far_x = 8'd0;
         far_y = 8'd0;
         err_acc = 16'd0;
         err_step = 16'd0;
         swapped = 1'b0;
         step_left = 1'b0;
         steps_left = 8'd0;
         mode = MODE_IDLE;
         phase = PH_NEAR_END;
         color = 8'd0;
         swept = 1'b0;
         failures = 0;
         pending_pixels.delete();
      end else begin
         // results first: a pixel never leaves on the edge its fetch is taken
         if (rsp_tvalid && rsp_tready) begin
            if (pending_pixels.size() == 0) begin
               report_mismatch("unexpected pixel word, x", int'(rsp_tdata[7:0]), 0);
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_tdata[7:0] !== want.x)
                  report_mismatch("pixel_x", int'(rsp_tdata[7:0]), int'(want.x));
               if (rsp_tdata[15:8] !== want.y)
                  report_mismatch("pixel_y", int'(rsp_tdata[15:8]), int'(want.y));
               if (rsp_tdata[23:16] !== want.weight)
                  report_mismatch("weight", int'(rsp_tdata[23:16]), int'(want.weight));
               if (rsp_tdata[31:24] !== want.color)
                  report_mismatch("color_out", int'(rsp_tdata[31:24]), int'(want.color));
               if (rsp_tuser !== want.kind)
                  report_mismatch("pixel_kind", int'(rsp_tuser), int'(want.kind));
               if (rsp_tlast !== want.last)
                  report_mismatch("last", int'(rsp_tlast), int'(want.last));
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == REQ_START)
               load_line(req_tdata);
            else
               next_pixel();
         end
         if (run_over && !swept) begin
            while (pending_pixels.size() != 0) begin
               want = pending_pixels.pop_front();
               report_mismatch("missing pixel word, x", 0, int'(want.x));
            end
            swept = 1'b1;
         end
      end
      pending <= pending_pixels.size();
   end

endmodule

FILE: tb/antialiased_line_pixel_walker_core_tb.sv
// Testbench top for the line walker core: stimulus, ready toggling, timeout and verdict.
module antialiased_line_pixel_walker_core_tb;
   import alpw_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEM_TARGET = 1830;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        run_over;
   logic        no_idle;
   logic        drained;
   int          failures;
   int          pending;
   int          cycle_count = 0;
   int          items_sent = 0;

   antialiased_line_pixel_walker_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   alpw_pixel_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .run_over   (run_over),
      .failures   (failures),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_tready <= no_idle || ($urandom_range(99) >= 15);

   task automatic send_word(input logic sel, input logic [39:0] d);
      while (!no_idle && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tuser <= sel;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic start_line(input logic [7:0] x1, input logic [7:0] y1,
                             input logic [7:0] x2, input logic [7:0] y2,
                             input logic [7:0] color);
      send_word(REQ_START, {color, y2, x2, y1, x1});
   endtask

   // fetch payload is ignored by the block; keep it random
   task automatic fetch_pixels(input int count);
      for (int i = 0; i < count; i++)
         send_word(REQ_FETCH, {8'($urandom), $urandom});
   endtask

   function automatic int line_length(input logic [7:0] x1, input logic [7:0] y1,
                                      input logic [7:0] x2, input logic [7:0] y2);
      int dx, dy, major, minor;
      dx = (x1 > x2) ? int'(x1) - int'(x2) : int'(x2) - int'(x1);
      dy = (y1 > y2) ? int'(y1) - int'(y2) : int'(y2) - int'(y1);
      major = (dx > dy) ? dx : dy;
      minor = (dx > dy) ? dy : dx;
      if (minor == 0)
         return major + 3;
      if (minor == major)
         return major + 2;
      return 2 + 4 * (major / 2);
   endfunction

   // step away from v by d, in a random direction that stays on screen
   function automatic logic [7:0] offset_coord(input logic [7:0] v, input int d);
      int vi;
      vi = int'(v);
      if (($urandom_range(1) == 1 && vi >= d) || vi + d > 255)
         return 8'(vi - d);
      return 8'(vi + d);
   endfunction

   task automatic random_line();
      logic [7:0] x1, y1, x2, y2;
      int         shape, d, count;
      x1 = 8'($urandom_range(255));
      y1 = 8'($urandom_range(255));
      shape = $urandom_range(49);
      d = $urandom_range(12, 1);
      case (shape)
         0: begin
            x2 = 8'($urandom_range(255));
            y2 = 8'($urandom_range(255));
         end
         1, 2: begin
            x2 = x1;
            y2 = y1;
         end
         3, 4, 5, 6: begin
            x2 = offset_coord(x1, d);
            y2 = y1;
         end
         7, 8, 9, 10: begin
            x2 = x1;
            y2 = offset_coord(y1, d);
         end
         11, 12, 13, 14, 15, 16: begin
            x2 = offset_coord(x1, d);
            y2 = offset_coord(y1, d);
         end
         default: begin
            x2 = offset_coord(x1, $urandom_range(12));
            y2 = offset_coord(y1, $urandom_range(12));
         end
      endcase
      count = line_length(x1, y1, x2, y2);
      // mostly full walks; some cut short by the next start, some with idle fetches after
      case ($urandom_range(9))
         0: count = $urandom_range(count - 1);
         1: count = count + $urandom_range(3, 1);
         default: ;
      endcase
      start_line(x1, y1, x2, y2, 8'($urandom_range(255)));
      fetch_pixels(count);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = REQ_FETCH;
      run_over = 1'b0;
      no_idle = 1'b0;
      drained = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // fetch with no line loaded
      send_word(REQ_FETCH, 40'hFF_FFFF_FFFF);
      // single point at the far corner
      start_line(8'd255, 8'd255, 8'd255, 8'd255, 8'hFF);
      fetch_pixels(3);
      // steep weighted line stepping left, then a fetch after its last pixel
      start_line(8'd0, 8'd255, 8'd1, 8'd253, 8'h00);
      fetch_pixels(7);
      // horizontal span at the right edge, axes swapped
      start_line(8'd254, 8'd0, 8'd255, 8'd0, 8'hA5);
      fetch_pixels(4);
      // diagonal cut short by a new start
      start_line(8'd3, 8'd3, 8'd1, 8'd5, 8'h5A);
      fetch_pixels(1);
      // shallow weighted line
      start_line(8'd0, 8'd0, 8'd2, 8'd1, 8'h3C);
      fetch_pixels(6);

      while (items_sent < ITEM_TARGET) begin
         if (!drained && items_sent >= 1100) begin
            // hold the sender until every pixel has come back
            req_tvalid <= 1'b0;
            do @(posedge clock); while (pending != 0);
            drained = 1'b1;
         end
         no_idle <= (items_sent >= 500 && items_sent < 800);
         random_line();
      end

      req_tvalid <= 1'b0;
      no_idle <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
      run_over <= 1'b1;
      repeat (2) @(posedge clock);
      if (failures == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

FILE: filelist.f
design/alpw_pkg.sv
design/alpw_ctrl.sv
design/alpw_datapath.sv
design/antialiased_line_pixel_walker_core.sv
tb/alpw_pixel_checker.sv
tb/antialiased_line_pixel_walker_core_tb.sv
